@@ design/assert_macros.svh @@
// Assertion helpers for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset
`define LSF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising edge outside reset
`define LSF_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`else

`define LSF_ASSERT(label, clk, rst_n, prop, msg)
`define LSF_ASSERT_IMP(label, clk, rst_n, pre, post, msg)

`endif

`endif

@@ design/lsf_pkg.sv @@
package lsf_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int TEXT_MAX    = 4096;

    localparam int POS_W       = 13;
    localparam int LEN_W       = 5;
    localparam int WIN_IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [7:0]       NEWLINE_BYTE   = 8'd10;
    localparam logic [LEN_W-1:0] PATTERN_LEN_RESET = LEN_W'(1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [LEN_W-1:0]             length;
        logic [PATTERN_MAX-1:0][7:0]  pattern;   // pattern[k] is byte k
    } cfg_t;

    typedef struct packed {
        logic       end_of_text;
        logic [7:0] text_byte;
    } item_t;

    // Input register contents handed to the match core
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        logic [POS_W-1:0] line_offset;
        logic [POS_W-1:0] line_length;
        logic [POS_W-1:0] line_index;
        logic             text_done;
    } result_t;

    // Control between the result register and the rest of the pipe
    typedef struct packed {
        logic advance;     // result slot free: the pipe moves this cycle
        logic out_valid;   // a result is held for the sink
    } pipe_ctrl_t;

endpackage

@@ design/lsf_if.sv @@
// Text byte channel
interface lsf_text_if;
    import lsf_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Matching line channel
interface lsf_line_if;
    import lsf_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] line_offset;
    logic [POS_W-1:0] line_length;
    logic [POS_W-1:0] line_index;
    logic             text_done;

    modport source (output valid, output line_offset, output line_length,
                    output line_index, output text_done, input ready);
    modport sink   (input valid, input line_offset, input line_length,
                    input line_index, input text_done, output ready);
endinterface

@@ design/line_substring_filter_unit.sv @@
// Line substring filter. Takes one text byte per cycle on text_in and reports on
// line_out every line (ended by a newline byte or by an end_of_text request) that
// contains the configured pattern of 1 to 16 bytes, with the line's start offset,
// length, index and whether end of text closed it. Throughput is one request per
// clock while the sink keeps up; a request passes an input register and is compared
// combinationally against a 16-byte shift window, and a line that it closes is held
// in the result register. While a line waits for the sink, one further byte is held
// in the input register and the input then stalls until the sink takes the line.
// Positions saturate at 4096 bytes; later bytes up to end of text are dropped.
// Write the pattern registers only while the unit is idle.
`include "assert_macros.svh"

module line_substring_filter_unit
    import lsf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    lsf_text_if.sink               text_in,
    lsf_line_if.source             line_out,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg;
    stage_t     stage;
    pipe_ctrl_t ctrl;
    logic       res_valid;
    result_t    res;

    lsf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsf_input_stage u_input (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .ctrl    (ctrl),
        .stage   (stage)
    );

    lsf_match_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .stage     (stage),
        .ctrl      (ctrl),
        .res_valid (res_valid),
        .res       (res)
    );

    lsf_output_stage u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .line_out  (line_out),
        .ctrl      (ctrl)
    );

    // Checks
    `LSF_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !stage.valid, text_in.ready, "input stage empty but not ready")
    `LSF_ASSERT_IMP(a_held_when_blocked, clk, rst_n, stage.valid && !ctrl.advance, ##1 stage.valid, "held request lost while blocked")
    `LSF_ASSERT_IMP(a_line_nonempty, clk, rst_n, ctrl.out_valid, line_out.line_length != '0, "matching line reported with no bytes")
    `LSF_ASSERT_IMP(a_index_le_offset, clk, rst_n, ctrl.out_valid, line_out.line_index <= line_out.line_offset, "line index beyond its offset")
    `LSF_ASSERT_IMP(a_line_in_text, clk, rst_n, ctrl.out_valid, ({1'b0, line_out.line_offset} + {1'b0, line_out.line_length}) <= (POS_W + 1)'(TEXT_MAX), "line runs past the text limit")

endmodule

@@ design/lsf_cfg_regs.sv @@
module lsf_cfg_regs
    import lsf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [LEN_W-1:0]      length_reg, length_next;
    logic [CFG_DATA_W-1:0] low_reg, low_next;
    logic [CFG_DATA_W-1:0] high_reg, high_next;

    // Register decode
    always_comb
    begin
        length_next = length_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LENGTH: length_next = cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    low_next    = cfg_data;
                REG_PATTERN_HIGH:   high_next   = cfg_data;
                default:            ;   // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= PATTERN_LEN_RESET;
            low_reg    <= '0;
            high_reg   <= '0;
        end
        else
        begin
            length_reg <= length_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
        end
    end

    assign cfg.length  = length_reg;
    assign cfg.pattern = {high_reg, low_reg};

endmodule

@@ design/lsf_input_stage.sv @@
module lsf_input_stage
    import lsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lsf_text_if.sink   text_in,
    input  pipe_ctrl_t ctrl,
    output stage_t     stage
);

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  accept;

    // Take a new request when none is held or the held one leaves this cycle
    assign text_in.ready = !valid_reg || ctrl.advance;
    assign accept        = text_in.valid && text_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (ctrl.advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.text_byte   <= text_in.text_byte;
            item_reg.end_of_text <= text_in.end_of_text;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ design/lsf_match_core.sv @@
module lsf_match_core
    import lsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  stage_t     stage,
    input  pipe_ctrl_t ctrl,
    output logic       res_valid,
    output result_t    res
);

    logic [PATTERN_MAX-1:0][7:0] window_reg, window_next, window_shift;
    logic [LEN_W-1:0]            count_reg, count_next, count_shift;
    logic                        match_reg, match_next;
    logic [POS_W-1:0]            pos_reg, pos_next, pos_inc;
    logic [POS_W-1:0]            begin_reg, begin_next;
    logic [POS_W-1:0]            line_reg, line_next;

    logic                        step;
    logic [LEN_W-1:0]            len_eff;
    logic [PATTERN_MAX-1:0]      pos_ok;
    logic [LEN_W-1:0]            pat_idx [PATTERN_MAX];
    logic                        hit;

    assign step    = stage.valid && ctrl.advance;
    assign pos_inc = pos_reg + POS_W'(1);

    // Window after taking the byte, newest in entry 0
    assign window_shift = {window_reg[PATTERN_MAX-2:0], stage.item.text_byte};
    assign count_shift  = (count_reg < LEN_W'(PATTERN_MAX)) ? count_reg + LEN_W'(1)
                                                            : count_reg;

    // Effective pattern length, clipped to the window size
    assign len_eff = (cfg.length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : cfg.length;

    // Window entry j lines up with pattern byte len_eff-1-j
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            pat_idx[j] = len_eff - LEN_W'(j) - LEN_W'(1);
            pos_ok[j]  = (LEN_W'(j) >= len_eff) ||
                         (window_shift[j] == cfg.pattern[pat_idx[j][WIN_IDX_W-1:0]]);
        end
    end

    assign hit = (len_eff != '0) && (count_shift >= len_eff) && (&pos_ok);

    // State update and line close
    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        match_next  = match_reg;
        pos_next    = pos_reg;
        begin_next  = begin_reg;
        line_next   = line_reg;
        res_valid   = 1'b0;

        res.line_offset = begin_reg;
        res.line_length = pos_reg - begin_reg;
        res.line_index  = line_reg;
        res.text_done   = stage.item.end_of_text;

        if (step)
        begin
            if (stage.item.end_of_text)
            begin
                // end of text: report, then start a fresh text
                res_valid   = match_reg;
                window_next = '0;
                count_next  = '0;
                match_next  = 1'b0;
                pos_next    = '0;
                begin_next  = '0;
                line_next   = '0;
            end
            else if (pos_reg < POS_W'(TEXT_MAX))
            begin
                if (stage.item.text_byte == NEWLINE_BYTE)
                begin
                    res_valid   = match_reg;
                    window_next = '0;
                    count_next  = '0;
                    match_next  = 1'b0;
                    pos_next    = pos_inc;
                    begin_next  = pos_inc;
                    line_next   = line_reg + POS_W'(1);
                end
                else
                begin
                    window_next = window_shift;
                    count_next  = count_shift;
                    pos_next    = pos_inc;
                    match_next  = match_reg || hit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            match_reg  <= 1'b0;
            pos_reg    <= '0;
            begin_reg  <= '0;
            line_reg   <= '0;
        end
        else
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
            match_reg  <= match_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            line_reg   <= line_next;
        end
    end

endmodule

@@ design/lsf_output_stage.sv @@
module lsf_output_stage
    import lsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  result_t     res,
    lsf_line_if.source  line_out,
    output pipe_ctrl_t  ctrl
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    free;

    // Slot is free when empty or being taken this cycle
    assign free = !valid_reg || line_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
            valid_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (free && res_valid)
            data_reg <= res;
    end

    assign line_out.valid       = valid_reg;
    assign line_out.line_offset = data_reg.line_offset;
    assign line_out.line_length = data_reg.line_length;
    assign line_out.line_index  = data_reg.line_index;
    assign line_out.text_done   = data_reg.text_done;

    assign ctrl.advance   = free;
    assign ctrl.out_valid = valid_reg;

endmodule
